/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// concurrent property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

/* rtl/core/ntcti_pkg.sv */
package ntcti_pkg;

    localparam int TABLE_ENTRIES = 156;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SUM_W         = 16;
    localparam int TEMP_W        = 16;
    localparam int START_W       = 12;
    localparam int STEP_W        = 7;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int PROD_W        = SUM_W + STEP_W;
    // step * (sum - right) + span / 2 stays below 2^17 for this table
    localparam int NUM_W         = SUM_W + 1;
    localparam int DIV_CNT_W     = $clog2(NUM_W + 1);
    localparam int RES_W         = PROD_W + 2;
    localparam int TEMP_MAX      = 2 ** (TEMP_W - 1) - 1;
    localparam int TEMP_MIN      = -(2 ** (TEMP_W - 1));

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [SUM_W-1:0] sum_t;

    // strictly falling divider sums, entry i is the sum at temperature table_start + i * table_step
    localparam sum_t SUM_TABLE [TABLE_ENTRIES] = '{
        16'd62603, 16'd62459, 16'd62310, 16'd62155, 16'd61995, 16'd61828, 16'd61655, 16'd61475,
        16'd61289, 16'd61096, 16'd60897, 16'd60690, 16'd60477, 16'd60256, 16'd60028, 16'd59793,
        16'd59550, 16'd59299, 16'd59041, 16'd58775, 16'd58501, 16'd58215, 16'd57920, 16'd57618,
        16'd57307, 16'd56988, 16'd56661, 16'd56327, 16'd55984, 16'd55634, 16'd55275, 16'd54906,
        16'd54530, 16'd54146, 16'd53753, 16'd53353, 16'd52944, 16'd52527, 16'd52102, 16'd51670,
        16'd51231, 16'd50786, 16'd50334, 16'd49876, 16'd49411, 16'd48940, 16'd48461, 16'd47976,
        16'd47485, 16'd46989, 16'd46489, 16'd45975, 16'd45458, 16'd44936, 16'd44410, 16'd43880,
        16'd43345, 16'd42807, 16'd42267, 16'd41724, 16'd41179, 16'd40633, 16'd40087, 16'd39539,
        16'd38991, 16'd38442, 16'd37892, 16'd37341, 16'd36791, 16'd36242, 16'd35694, 16'd35145,
        16'd34597, 16'd34051, 16'd33507, 16'd32967, 16'd32427, 16'd31890, 16'd31357, 16'd30828,
        16'd30303, 16'd29779, 16'd29259, 16'd28745, 16'd28235, 16'd27730, 16'd27228, 16'd26732,
        16'd26241, 16'd25756, 16'd25277, 16'd24801, 16'd24332, 16'd23869, 16'd23412, 16'd22961,
        16'd22515, 16'd22075, 16'd21642, 16'd21216, 16'd20796, 16'd20386, 16'd19983, 16'd19586,
        16'd19196, 16'd18813, 16'd18435, 16'd18064, 16'd17699, 16'd17341, 16'd16989, 16'd16641,
        16'd16299, 16'd15964, 16'd15635, 16'd15312, 16'd14995, 16'd14684, 16'd14379, 16'd14080,
        16'd13787, 16'd13501, 16'd13221, 16'd12947, 16'd12679, 16'd12416, 16'd12157, 16'd11904,
        16'd11657, 16'd11415, 16'd11178, 16'd10944, 16'd10715, 16'd10491, 16'd10272, 16'd10057,
        16'd9847,  16'd9641,  16'd9440,  16'd9243,  16'd9050,  16'd8861,  16'd8675,  16'd8494,
        16'd8317,  16'd8144,  16'd7974,  16'd7808,  16'd7646,  16'd7487,  16'd7332,  16'd7180,
        16'd7031,  16'd6886,  16'd6744,  16'd6605
    };

    localparam sum_t FIRST_SUM = SUM_TABLE[0];
    localparam sum_t LAST_SUM  = SUM_TABLE[TABLE_ENTRIES-1];
    localparam idx_t LAST_IDX  = idx_t'(TABLE_ENTRIES - 1);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_IN    = 2'd0,
        STATUS_BELOW = 2'd1,
        STATUS_ABOVE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_START   = 3'd0,
        CFG_TABLE_STEP    = 3'd1,
        CFG_SENTINEL_MODE = 3'd2,
        CFG_UNDER_VALUE   = 3'd3,
        CFG_OVER_VALUE    = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_LOAD_LO,
        ST_LOAD_HI,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        sum_t             divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

    function automatic sum_t rom_read(idx_t addr);
        return SUM_TABLE[addr];
    endfunction

endpackage

/* rtl/core/ntcti_div.sv */
// restoring divider, one quotient bit per cycle
module ntcti_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ntcti_pkg::div_req_t  req,
    output ntcti_pkg::div_rsp_t  rsp
);
    import ntcti_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    sum_t                 rem_reg, rem_next;
    sum_t                 divisor_reg, divisor_next;

    logic [SUM_W:0]   rem_shift;
    logic [SUM_W+1:0] trial;
    logic             ge;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, divisor_reg};
        ge        = !trial[SUM_W+1];

        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;

        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = DIV_CNT_W'(NUM_W);
            quo_next     = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? trial[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* rtl/core/ntc_table_temperature_interp_unit.sv */
// channel  | direction | signals                                  | transfer
// ---------+-----------+------------------------------------------+---------------------
// s_       | in        | s_valid, s_ready, s_adc_sum              | valid & ready
// m_       | out       | m_valid, m_ready, m_temperature,         | valid & ready
//          |           | m_range_status                           |
// cfg_     | in        | cfg_wr_en, cfg_index, cfg_wdata          | write when cfg_wr_en
//
// in-table sums run 7 or 8 search probes, an exit check, two bracket reads, the offset multiply,
// a 17 step divide with its done strobe, the base multiply and the result load (an exact hit
// or a flat bracket skips the divide); clamped end sums just scale and load, sentinels just load
// one transaction is in flight at a time; s_ready is high only when the sequencer idles
// the result register lets the next transaction enter while m_ready is held low
// reset (synchronous, active low) restores the register defaults and empties the block
`include "assert_macros.svh"

module ntc_table_temperature_interp_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input transactions
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ntcti_pkg::SUM_W-1:0]     s_adc_sum,
    // result transactions
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ntcti_pkg::TEMP_W-1:0]    m_temperature,
    output logic [ntcti_pkg::STATUS_W-1:0]  m_range_status,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [ntcti_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ntcti_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ntcti_pkg::*;

    // configuration registers
    logic signed [START_W-1:0] table_start_reg;
    logic [STEP_W-1:0]         table_step_reg;
    logic                      sentinel_mode_reg;
    logic [TEMP_W-1:0]         under_value_reg;
    logic [TEMP_W-1:0]         over_value_reg;

    // sequencer state
    state_t state_reg, state_next;

    // per-transaction working registers
    sum_t              sum_reg, sum_next;
    idx_t              lo_reg, lo_next;
    idx_t              hi_reg, hi_next;
    sum_t              vl_reg, vl_next;
    sum_t              span_reg, span_next;
    sum_t              diff_reg, diff_next;
    logic [PROD_W-1:0] mul_reg, mul_next;
    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic              sent_reg, sent_next;
    logic [TEMP_W-1:0] sent_val_reg, sent_val_next;
    status_t           status_reg, status_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [TEMP_W-1:0] temp_out_reg, temp_out_next;
    status_t           status_out_reg, status_out_next;

    // shared datapath
    idx_t              rom_addr;
    sum_t              rom_data;
    logic [IDX_W:0]    mid_sum;
    idx_t              mid;
    sum_t              mul_a;
    logic [PROD_W-1:0] mul_prod;
    logic [PROD_W-1:0] num;
    logic signed [RES_W-1:0] res;
    logic [TEMP_W-1:0] res_sat;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_start_reg   <= '0;
            table_step_reg    <= STEP_W'(10);
            sentinel_mode_reg <= 1'b0;
            under_value_reg   <= TEMP_W'(TEMP_MAX);
            over_value_reg    <= TEMP_W'(TEMP_MIN);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TABLE_START:   table_start_reg   <= cfg_wdata[START_W-1:0];
                CFG_TABLE_STEP:    table_step_reg    <= cfg_wdata[STEP_W-1:0];
                CFG_SENTINEL_MODE: sentinel_mode_reg <= cfg_wdata[0];
                CFG_UNDER_VALUE:   under_value_reg   <= cfg_wdata[TEMP_W-1:0];
                CFG_OVER_VALUE:    over_value_reg    <= cfg_wdata[TEMP_W-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // midpoint of the current bracket
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];

    // single table read port: probe during search, then the two bracket ends
    always_comb begin
        case (state_reg)
            ST_SEARCH:  rom_addr = mid;
            ST_LOAD_LO: rom_addr = lo_reg;
            default:    rom_addr = hi_reg;
        endcase
    end
    assign rom_data = rom_read(rom_addr);

    // shared multiplier: step * sum offset for the correction, step * index for the base
    assign mul_a    = (state_reg == ST_MUL) ? diff_reg : SUM_W'(hi_reg);
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(table_step_reg);
    // rounding: half the bracket span added before the truncating divide
    assign num      = mul_prod + PROD_W'(span_reg >> 1);

    // base temperature minus rounded correction, clipped to 16 bits
    always_comb begin
        res = RES_W'(table_start_reg) + RES_W'(mul_reg) - RES_W'(quot_reg);
        if (res > RES_W'(TEMP_MAX)) begin
            res_sat = TEMP_W'(TEMP_MAX);
        end else if (res < RES_W'(TEMP_MIN)) begin
            res_sat = TEMP_W'(TEMP_MIN);
        end else begin
            res_sat = res[TEMP_W-1:0];
        end
    end

    ntcti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        vl_next         = vl_reg;
        span_next       = span_reg;
        diff_next       = diff_reg;
        mul_next        = mul_reg;
        quot_next       = quot_reg;
        sent_next       = sent_reg;
        sent_val_next   = sent_val_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        temp_out_next   = temp_out_reg;
        status_out_next = status_out_reg;

        div_req.start    = 1'b0;
        div_req.dividend = num[NUM_W-1:0];
        div_req.divisor  = span_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sum_next   = s_adc_sum;
                    sent_next  = 1'b0;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK: begin
                quot_next   = '0;
                status_next = STATUS_IN;
                if (sum_reg <= LAST_SUM) begin
                    // hot end: at or below the last entry
                    if (sum_reg < LAST_SUM) begin
                        status_next = STATUS_BELOW;
                    end
                    if (sum_reg < LAST_SUM && sentinel_mode_reg) begin
                        sent_next     = 1'b1;
                        sent_val_next = under_value_reg;
                        state_next    = ST_FINISH;
                    end else begin
                        hi_next    = LAST_IDX;
                        state_next = ST_SCALE;
                    end
                end else if (sum_reg >= FIRST_SUM) begin
                    // cold end: at or above the first entry
                    if (sum_reg > FIRST_SUM) begin
                        status_next = STATUS_ABOVE;
                    end
                    if (sum_reg > FIRST_SUM && sentinel_mode_reg) begin
                        sent_next     = 1'b1;
                        sent_val_next = over_value_reg;
                        state_next    = ST_FINISH;
                    end else begin
                        hi_next    = '0;
                        state_next = ST_SCALE;
                    end
                end else begin
                    lo_next    = '0;
                    hi_next    = LAST_IDX;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                // keep table[lo] >= sum > table[hi]
                if ((hi_reg - lo_reg) > IDX_W'(1)) begin
                    if (sum_reg > rom_data) begin
                        hi_next = mid;
                    end else begin
                        lo_next = mid;
                    end
                end else begin
                    state_next = ST_LOAD_LO;
                end
            end

            ST_LOAD_LO: begin
                if (sum_reg >= rom_data) begin
                    // exact hit on the upper bracket entry
                    hi_next    = lo_reg;
                    quot_next  = '0;
                    state_next = ST_SCALE;
                end else begin
                    vl_next    = rom_data;
                    state_next = ST_LOAD_HI;
                end
            end

            ST_LOAD_HI: begin
                span_next  = (vl_reg > rom_data) ? (vl_reg - rom_data) : '0;
                diff_next  = sum_reg - rom_data;
                state_next = ST_MUL;
            end

            ST_MUL: begin
                if (span_reg == '0) begin
                    // flat bracket, no correction
                    quot_next  = '0;
                    state_next = ST_SCALE;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end

            ST_DIV: begin
                if (div_rsp.done) begin
                    quot_next  = div_rsp.quotient;
                    state_next = ST_SCALE;
                end
            end

            ST_SCALE: begin
                mul_next   = mul_prod;
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    temp_out_next   = sent_reg ? sent_val_reg : res_sat;
                    status_out_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        sum_reg        <= sum_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        vl_reg         <= vl_next;
        span_reg       <= span_next;
        diff_reg       <= diff_next;
        mul_reg        <= mul_next;
        quot_reg       <= quot_next;
        sent_reg       <= sent_next;
        sent_val_reg   <= sent_val_next;
        status_reg     <= status_next;
        temp_out_reg   <= temp_out_next;
        status_out_reg <= status_out_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_temperature  = temp_out_reg;
    assign m_range_status = status_out_reg;

    // bracket never collapses or inverts during the search
    `ASSERT_CLK(a_search_order, aclk, aresetn, (state_reg == ST_SEARCH) |-> (lo_reg < hi_reg), "search bracket inverted")
    // the divider is only started when it is free
    `ASSERT_NEVER(a_div_restart, aclk, aresetn, div_req.start && div_rsp.busy, "divider restarted while busy")
    // a sentinel result always carries an out-of-table status
    `ASSERT_CLK(a_sentinel_status, aclk, aresetn, (state_reg == ST_FINISH && sent_reg) |-> (status_reg != STATUS_IN), "sentinel with in-table status")
    // a finished result waits while the output register is still occupied
    `ASSERT_CLK(a_finish_holds, aclk, aresetn, (state_reg == ST_FINISH && m_valid_reg && !m_ready) |=> (state_reg == ST_FINISH), "result register overwritten")

endmodule
